[design/vef_pkg.sv]
// Shared constants and types for the vendor element finder.
`timescale 1ns / 1ps
`default_nettype none

package vef_pkg;

    // Default frame geometry
    localparam int HEADER_SKIP_BYTES_DEF = 24;
    localparam int MAX_FRAME_BYTES_DEF   = 4095;

    // Beacon body constants
    localparam int         FIXED_BEACON_BYTES = 12;
    localparam logic [7:0] VENDOR_ID          = 8'hdd;
    localparam logic [7:0] OUI_BYTES          = 8'd4;
    localparam logic [31:0] OUI_RESET         = {8'h00, 8'h09, 8'hbf, 8'h00};

    // Output field widths
    localparam int OFFSET_W = 12;
    localparam int LENGTH_W = 8;
    localparam int RESULT_W = 1 + OFFSET_W + LENGTH_W + 1;
    localparam int RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    // One frame verdict
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] payload_offset;
        logic [LENGTH_W-1:0] payload_length;
        logic                frame_too_long;
    } vef_result_t;

endpackage : vef_pkg

`default_nettype wire

[design/vendor_element_finder_core.sv]
// Top level of the vendor element finder: byte parser plus output register and skid stage.
//
//  channel   | direction | beat content
//  ----------+-----------+------------------------------------------------------------
//  s_axis    | in        | one frame byte in tdata, tlast on the final byte
//  m_axis    | out       | one verdict per frame: found, offset, length, too_long
//  cfg       | in        | write of the 32-bit OUI match register
//
// One byte is taken every cycle while the skid entry is empty; the parser state is updated in the same cycle.
// The verdict of a frame is formed from its last byte and registered in the output register, or in the skid entry.
// An output register plus one skid entry decouple the sides; s_axis stalls only
// while the skid entry is occupied.
// Reset clears the parser and the valid flags of both output stages, and loads the default OUI.
`timescale 1ns / 1ps
`default_nettype none

module vendor_element_finder_core #(
    parameter int HEADER_SKIP_BYTES = vef_pkg::HEADER_SKIP_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = vef_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  wire logic                                s_axis_tlast,  // last_byte
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] found, [12:1] payload_offset, [20:13] payload_length, [21] frame_too_long
    output logic [vef_pkg::RESULT_BYTES_W-1:0]       m_axis_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [31:0]                         cfg_wr_data
);

    logic                 beat_take;
    logic                 res_valid;
    vef_pkg::vef_result_t res;

    logic                 out_valid_reg;
    vef_pkg::vef_result_t out_reg;
    logic                 skid_valid_reg;
    vef_pkg::vef_result_t skid_reg;
    logic                 out_free;

    assign s_axis_tready = !skid_valid_reg;
    assign beat_take     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    vef_parser #(
        .HEADER_SKIP_BYTES (HEADER_SKIP_BYTES),
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_take   (beat_take),
        .beat_byte   (s_axis_tdata),
        .beat_last   (s_axis_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Move verdicts through the output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_axis_tready)
                    skid_valid_reg <= 1'b0;
            end
            else if (res_valid && !out_free)
            begin
                skid_valid_reg <= 1'b1;
            end

            if (out_free)
                out_valid_reg <= skid_valid_reg || res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_free)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = vef_pkg::RESULT_BYTES_W'({out_reg.frame_too_long,
                                                     out_reg.payload_length,
                                                     out_reg.payload_offset,
                                                     out_reg.found});

`ifndef NO_ASSERTIONS
    // Skid entry is only ever occupied behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A verdict only appears after a last beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(beat_take && s_axis_tlast)) |=> !out_valid_reg)
        else $error("verdict without a last beat");

    // Offset and length are zero when no element was found
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |->
            (out_reg.payload_offset == '0 && out_reg.payload_length == '0))
        else $error("nonzero payload fields without a match");
`endif

endmodule : vendor_element_finder_core

`default_nettype wire

[design/vef_parser.sv]
// Byte-wise beacon element walker with the OUI register and frame verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module vef_parser #(
    parameter int HEADER_SKIP_BYTES = vef_pkg::HEADER_SKIP_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = vef_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               beat_take,
    input  wire logic [7:0]         beat_byte,
    input  wire logic               beat_last,
    output logic                    res_valid,
    output vef_pkg::vef_result_t    res
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFF_W = (POS_W + 1 > vef_pkg::OFFSET_W) ? POS_W + 1 : vef_pkg::OFFSET_W;
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] SKIP_LAST =
        POS_W'(HEADER_SKIP_BYTES + vef_pkg::FIXED_BEACON_BYTES - 1);

    localparam logic [2:0] PH_SKIP = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    logic [31:0]                   oui_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [2:0]                    phase_reg, phase_next;
    logic                          vendor_reg, vendor_next;
    logic [7:0]                    elen_reg, elen_next;
    logic [7:0]                    left_reg, left_next;
    logic                          oui_ok_reg, oui_ok_next;
    logic                          done_reg, done_next;
    logic [vef_pkg::OFFSET_W-1:0]  moff_reg, moff_next;
    logic [vef_pkg::LENGTH_W-1:0]  mlen_reg, mlen_next;
    logic                          ovf_reg, ovf_next;

    logic [7:0]       body_idx;
    logic [7:0]       want_byte;
    logic [7:0]       left_dec;
    logic [OFF_W-1:0] off_sum;

    // Pick the expected OUI byte for the current body index
    assign body_idx = elen_reg - left_reg;
    assign left_dec = left_reg - 8'd1;
    assign off_sum  = OFF_W'(pos_reg) + OFF_W'(5);

    always_comb
    begin
        case (body_idx[1:0])
            2'd0:    want_byte = oui_reg[31:24];
            2'd1:    want_byte = oui_reg[23:16];
            2'd2:    want_byte = oui_reg[15:8];
            default: want_byte = oui_reg[7:0];
        endcase
    end

    // Advance the walker by one byte, or flag overflow once the frame size limit is reached
    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        vendor_next = vendor_reg;
        elen_next   = elen_reg;
        left_next   = left_reg;
        oui_ok_next = oui_ok_reg;
        done_next   = done_reg;
        moff_next   = moff_reg;
        mlen_next   = mlen_reg;
        ovf_next    = ovf_reg;

        if (pos_reg == POS_MAX)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (pos_reg >= SKIP_LAST)
                        phase_next = PH_ID;
                end
                PH_ID:
                begin
                    vendor_next = (beat_byte == vef_pkg::VENDOR_ID);
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    elen_next   = beat_byte;
                    left_next   = beat_byte;
                    vendor_next = vendor_reg && (beat_byte >= vef_pkg::OUI_BYTES);
                    oui_ok_next = 1'b1;
                    if (vendor_reg && (beat_byte >= vef_pkg::OUI_BYTES))
                    begin
                        moff_next = off_sum[vef_pkg::OFFSET_W-1:0];
                        mlen_next = beat_byte - vef_pkg::OUI_BYTES;
                    end
                    phase_next = (beat_byte == 8'd0) ? PH_ID : PH_BODY;
                end
                PH_BODY:
                begin
                    if (vendor_reg && (body_idx[7:2] == 6'd0) && (beat_byte != want_byte))
                        oui_ok_next = 1'b0;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if (vendor_reg && oui_ok_next)
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end
    end

    // Form the verdict from the updated state on the last beat
    assign res_valid              = beat_take && beat_last;
    assign res.found              = done_next;
    assign res.payload_offset     = done_next ? moff_next : '0;
    assign res.payload_length     = done_next ? mlen_next : '0;
    assign res.frame_too_long     = ovf_next;

    // Hold the OUI register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oui_reg <= vef_pkg::OUI_RESET;
        else if (cfg_wr_en)
            oui_reg <= cfg_wr_data;
    end

    // Update walker state; clear it after the last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_SKIP;
            vendor_reg <= 1'b0;
            elen_reg   <= '0;
            left_reg   <= '0;
            oui_ok_reg <= 1'b0;
            done_reg   <= 1'b0;
            moff_reg   <= '0;
            mlen_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (beat_take)
        begin
            if (beat_last)
            begin
                pos_reg    <= '0;
                phase_reg  <= PH_SKIP;
                vendor_reg <= 1'b0;
                elen_reg   <= '0;
                left_reg   <= '0;
                oui_ok_reg <= 1'b0;
                done_reg   <= 1'b0;
                moff_reg   <= '0;
                mlen_reg   <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                phase_reg  <= phase_next;
                vendor_reg <= vendor_next;
                elen_reg   <= elen_next;
                left_reg   <= left_next;
                oui_ok_reg <= oui_ok_next;
                done_reg   <= done_next;
                moff_reg   <= moff_next;
                mlen_reg   <= mlen_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule : vef_parser

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the vendor element finder: beacon frames in, frame verdicts out.
`timescale 1ns / 1ps

module tb_top;

    localparam int SKIP_TOTAL      = vef_pkg::HEADER_SKIP_BYTES_DEF + vef_pkg::FIXED_BEACON_BYTES;
    localparam int MAX_BYTES       = vef_pkg::MAX_FRAME_BYTES_DEF;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_WAIT        = 8;
    localparam int IDLE_PERCENT    = 7;
    localparam int FRAMES_PER_STEP = 7;
    localparam logic [7:0] FILLER_ID = 8'h01;
    localparam logic [7:0] EMPTY_ID  = 8'h2a;
    localparam logic [7:0] PLAIN_ID  = 8'h30;

    typedef enum logic [2:0] {PH_HDR, PH_ID, PH_LEN, PH_BODY, PH_DONE} scan_phase_t;

    // One frame verdict, fields in the order of the packing below
    typedef struct packed {
        logic                         found;
        logic [vef_pkg::OFFSET_W-1:0] offset;
        logic [vef_pkg::LENGTH_W-1:0] length;
        logic                         too_long;
    } verdict_t;

    // One directed frame: header, optional element placed at id_pos, tail
    typedef struct {
        int          hdr_len;
        logic [7:0]  hdr_byte;
        int          id_pos;
        logic [7:0]  el_id;
        int          el_len;
        logic [31:0] el_oui;
        int          cut;
        bit          lone;
        int          total;
        bit          typed;
        verdict_t    want;
    } frame_case_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [vef_pkg::RESULT_BYTES_W-1:0] m_axis_tdata;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;

    // Predictor state
    logic [31:0]  oui_reg;
    int           scan_pos;
    scan_phase_t  scan_phase;
    bit           el_vendor;
    int           el_len;
    int           el_left;
    bit           oui_ok;
    bit           hit;
    logic [11:0]  hit_off;
    logic [7:0]   hit_len;
    bit           past_max;

    verdict_t     expected_verdicts[$];
    logic [7:0]   frame_q[$];
    frame_case_t  dir_cases[$];
    int           errors = 0;
    int           stall_cycles = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;
    verdict_t     mon_got;
    verdict_t     mon_want;

    vendor_element_finder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return the walker to the start of a frame
    function automatic void clear_scan();
        scan_pos   = 0;
        scan_phase = PH_HDR;
        el_vendor  = 1'b0;
        el_len     = 0;
        el_left    = 0;
        oui_ok     = 1'b0;
        hit        = 1'b0;
        hit_off    = '0;
        hit_len    = '0;
        past_max   = 1'b0;
    endfunction

    // Advance the walker by one byte; return 1 with the verdict on the last byte
    function automatic bit judge_byte(input logic [7:0] b, input bit last, output verdict_t v);
        int k;
        v = '0;
        if (scan_pos >= MAX_BYTES) begin
            past_max = 1'b1;
        end
        else begin
            case (scan_phase)
                PH_HDR:
                begin
                    if (scan_pos + 1 >= SKIP_TOTAL)
                        scan_phase = PH_ID;
                end
                PH_ID:
                begin
                    el_vendor  = (b == vef_pkg::VENDOR_ID);
                    scan_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    el_len    = b;
                    el_left   = b;
                    el_vendor = el_vendor && (b >= vef_pkg::OUI_BYTES);
                    oui_ok    = 1'b1;
                    if (el_vendor)
                    begin
                        hit_off = 12'(scan_pos + 5);
                        hit_len = b - vef_pkg::OUI_BYTES;
                    end
                    scan_phase = (b == 8'd0) ? PH_ID : PH_BODY;
                end
                PH_BODY:
                begin
                    k = el_len - el_left;
                    if (el_vendor && k < 4 && b != oui_reg[31 - 8 * k -: 8])
                        oui_ok = 1'b0;
                    el_left--;
                    if (el_left == 0)
                    begin
                        if (el_vendor && oui_ok)
                        begin
                            hit        = 1'b1;
                            scan_phase = PH_DONE;
                        end
                        else
                            scan_phase = PH_ID;
                    end
                end
                default: ;
            endcase
            scan_pos++;
        end
        if (!last)
            return 1'b0;
        v.found    = hit;
        v.offset   = hit ? hit_off : '0;
        v.length   = hit ? hit_len : '0;
        v.too_long = past_max;
        clear_scan();
        return 1'b1;
    endfunction

    // Append an element; only the first keep body bytes go out, OUI bytes lead the body
    function automatic void push_elem(input logic [7:0] id, input int len,
                                      input logic [31:0] oui, input int keep);
        frame_q.push_back(id);
        frame_q.push_back(8'(len));
        for (int i = 0; i < keep; i++)
        begin
            if (i < 4)
                frame_q.push_back(oui[31 - 8 * i -: 8]);
            else
                frame_q.push_back(8'($urandom));
        end
    endfunction

    // Fill with plain elements up to target bytes, ending on an element boundary
    function automatic void pad_to(input int target);
        int rem;
        int len;
        while (frame_q.size() < target)
        begin
            rem = target - frame_q.size();
            if (rem <= 8 && rem % 2 == 0)
            begin
                frame_q.push_back(EMPTY_ID);
                frame_q.push_back(8'h00);
            end
            else
            begin
                if (rem >= 259)
                    len = 255;
                else if (rem == 258)
                    len = 128;
                else
                    len = rem - 2;
                push_elem(FILLER_ID, len, $urandom, len);
            end
        end
    endfunction

    function automatic void add_case(input int hdr_len, input logic [7:0] hdr_byte,
                                     input int id_pos, input logic [7:0] el_id,
                                     input int el_len, input logic [31:0] el_oui,
                                     input int cut, input bit lone, input int total,
                                     input bit typed, input bit w_found, input int w_off,
                                     input int w_len, input bit w_long);
        frame_case_t c;
        c.hdr_len  = hdr_len;
        c.hdr_byte = hdr_byte;
        c.id_pos   = id_pos;
        c.el_id    = el_id;
        c.el_len   = el_len;
        c.el_oui   = el_oui;
        c.cut      = cut;
        c.lone     = lone;
        c.total    = total;
        c.typed    = typed;
        c.want     = {w_found, 12'(w_off), 8'(w_len), w_long};
        dir_cases.push_back(c);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(99) < 5)
            return $urandom_range(4, 255);
        return $urandom_range(4, 16);
    endfunction

    // Build a random frame: mostly well-formed element walks, some noise
    function automatic void rand_frame();
        int kind;
        int sel;
        int len;
        int tail;
        logic [31:0] oui;
        frame_q.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, SKIP_TOTAL)) frame_q.push_back(8'($urandom));
        end
        else if (kind < 14) begin
            repeat ($urandom_range(SKIP_TOTAL + 1, 100)) frame_q.push_back(8'($urandom));
        end
        else if (kind < 16) begin
            repeat ($urandom_range(MAX_BYTES - 5, MAX_BYTES + 25))
                frame_q.push_back(8'($urandom));
        end
        else begin
            repeat (SKIP_TOTAL) frame_q.push_back(8'($urandom));
            repeat ($urandom_range(0, 4))
            begin
                sel = $urandom_range(99);
                if (sel < 30) begin
                    len = pick_len();
                    push_elem(vef_pkg::VENDOR_ID, len, oui_reg, len);
                end
                else if (sel < 45) begin
                    len = pick_len();
                    oui = oui_reg ^ (32'h1 << $urandom_range(31));
                    push_elem(vef_pkg::VENDOR_ID, len, oui, len);
                end
                else if (sel < 55) begin
                    len = $urandom_range(0, 3);
                    push_elem(vef_pkg::VENDOR_ID, len, oui_reg, len);
                end
                else if (sel < 70) begin
                    push_elem(8'($urandom), 0, 32'h0, 0);
                end
                else begin
                    len = $urandom_range(0, 12);
                    push_elem(8'($urandom), len, $urandom, len);
                end
            end
            tail = $urandom_range(99);
            if (tail < 12) begin
                frame_q.push_back(8'($urandom));
            end
            else if (tail < 24) begin
                len = $urandom_range(4, 20);
                oui = ($urandom_range(1) == 1) ? oui_reg : $urandom;
                push_elem(($urandom_range(3) != 0) ? vef_pkg::VENDOR_ID : 8'($urandom),
                          len, oui, $urandom_range(0, len - 1));
            end
        end
    endfunction

    // Offer one beat and hold it until the block takes it
    task automatic drive_byte(input logic [7:0] b, input bit last);
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Send the frame in frame_q, queuing its verdict before the last beat goes out
    task automatic send_frame(input bit typed, input verdict_t want);
        verdict_t v;
        bit last;
        foreach (frame_q[i])
        begin
            last = (i == frame_q.size() - 1);
            if (judge_byte(frame_q[i], last, v))
                expected_verdicts.push_back(typed ? want : v);
            drive_byte(frame_q[i], last);
        end
    endtask

    // Drain all verdicts, let the block settle, then load a new OUI
    task automatic write_oui(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        oui_reg = value;
    endtask

    task automatic log_mismatch(input string what, input verdict_t want, input verdict_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected found=%0b offset=%0d length=%0d too_long=%0b",
                     $realtime, what, want.found, want.offset, want.length, want.too_long,
                     "  got found=%0b offset=%0d length=%0d too_long=%0b",
                     got.found, got.offset, got.length, got.too_long);
    endtask

    // Check each accepted verdict beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            mon_got = {m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tdata[20:13],
                       m_axis_tdata[21]};
            if (expected_verdicts.size() == 0)
                log_mismatch("verdict with none pending", '0, mon_got);
            else
            begin
                mon_want = expected_verdicts.pop_front();
                if (mon_got !== mon_want)
                    log_mismatch("verdict mismatch", mon_want, mon_got);
            end
        end
    end

    // End the run when neither side moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        logic [31:0] step_oui[8];
        oui_reg = vef_pkg::OUI_RESET;
        clear_scan();

        // Hold reset, then release at a clock edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames; typed verdicts where they are obvious
        //       hdr  hbyte  idpos id     len  oui                   cut lone total
        add_case(1,   8'h00, 0,    8'h00, 0,   32'h0,                0, 0, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'hff, 0,    8'h00, 0,   32'h0,                0, 0, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 8,   vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 1, 42, 4, 0);
        add_case(36,  8'h00, 36,   8'hdd, 4,   vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 1, 42, 0, 0);
        add_case(36,  8'hff, 36,   8'hdd, 255, vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 1, 42, 251, 0);
        add_case(36,  8'h00, 40,   8'hdd, 8,   vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 1, 46, 4, 0);
        add_case(36,  8'h00, 36,   8'hdd, 3,   vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 8,   vef_pkg::OUI_RESET ^ 32'h1, 0, 0, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 8,   vef_pkg::OUI_RESET,   1, 0, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'h01, 2,   32'h0,                0, 1, 0,
                 1, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   PLAIN_ID, 6, vef_pkg::OUI_RESET,  0, 0, 0,
                 0, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 8,   vef_pkg::OUI_RESET,   0, 1, 0,
                 0, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 0,   vef_pkg::OUI_RESET,   0, 0, 0,
                 0, 0, 0, 0, 0);
        add_case(36,  8'h00, 36,   8'hdd, 8,   vef_pkg::OUI_RESET,   0, 0, 4100,
                 1, 1, 42, 4, 1);
        add_case(36,  8'hff, 0,    8'h00, 0,   32'h0,                0, 0, 4100,
                 0, 0, 0, 0, 0);
        add_case(36,  8'h00, 4088, 8'hdd, 4,   vef_pkg::OUI_RESET,   0, 0, 0,
                 1, 1, 4094, 0, 0);
        add_case(36,  8'h00, 4088, 8'hdd, 4,   vef_pkg::OUI_RESET,   0, 0, 4096,
                 1, 1, 4094, 0, 1);

        foreach (dir_cases[n])
        begin
            frame_q.delete();
            repeat (dir_cases[n].hdr_len) frame_q.push_back(dir_cases[n].hdr_byte);
            if (dir_cases[n].id_pos != 0)
            begin
                pad_to(dir_cases[n].id_pos);
                push_elem(dir_cases[n].el_id, dir_cases[n].el_len, dir_cases[n].el_oui,
                          dir_cases[n].el_len - dir_cases[n].cut);
                if (dir_cases[n].lone)
                    frame_q.push_back(8'($urandom));
            end
            while (frame_q.size() < dir_cases[n].total)
                frame_q.push_back(8'h00);
            send_frame(dir_cases[n].typed, dir_cases[n].want);
        end

        // Random frames under several OUI settings, extremes included
        step_oui[0] = $urandom;
        step_oui[1] = 32'h0000_0000;
        step_oui[2] = 32'hffff_ffff;
        step_oui[3] = $urandom;
        step_oui[4] = vef_pkg::OUI_RESET;
        step_oui[5] = $urandom;
        step_oui[6] = $urandom;
        step_oui[7] = $urandom;
        for (int p = 0; p < 8; p++)
        begin
            write_oui(step_oui[p]);
            calm = (p == 2);
            // Stall the receiver and keep short frames coming to back up the input
            if (p == 4)
            begin
                hold_req = 1'b1;
                repeat (12)
                begin
                    frame_q.delete();
                    repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
                    send_frame(1'b0, '0);
                end
            end
            repeat (FRAMES_PER_STEP)
            begin
                rand_frame();
                send_frame(1'b0, '0);
            end
        end
        calm = 1'b0;

        // Drain and report
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
